// ===== rtl/core/tlpfs_pkg.sv =====
`default_nettype none
package tlpfs_pkg;

  localparam int NORMAL_BITS = 16;
  localparam int UNIT_BITS   = 17;
  localparam int HV_BITS     = 18;

  // register stages through one normalizer
  localparam int NRM_LAT = 55;

  localparam int UNIT_ONE   = 32768;
  localparam int CLAMP_ONE  = 65536;
  localparam int AMBIENT    = 3277;
  localparam int L1_COMP    = 18919;
  localparam int L2_COMP    = 23170;
  localparam int POW1       = 27307;
  localparam int POW2       = 40960;
  localparam int KSP1       = 21673;
  localparam int KSP2       = 32510;
  localparam int RECIP_255  = 65793;
  localparam int COLOR_MAX  = 255;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic [7:0] diffuse_red;
    logic [7:0] diffuse_green;
    logic [7:0] diffuse_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] shade_red;
    logic [7:0] shade_green;
    logic [7:0] shade_blue;
  } out_item_t;

  typedef struct packed {
    logic nz;
    logic [2:0][UNIT_BITS-1:0] u;
  } unit_vec_t;

endpackage
`default_nettype wire

// ===== rtl/core/tlpfs_normalize.sv =====
`default_nettype none
module tlpfs_normalize #(
  parameter int CW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [2:0][CW-1:0]    comp_in,
  output tlpfs_pkg::unit_vec_t       vec_out
);
  import tlpfs_pkg::*;

  localparam int PW = $clog2(CW + 21);
  localparam int SW = CW + 21;

  typedef struct packed {
    logic [2:0]       sgn;
    logic             zero;
    logic [2:0][20:0] am;
  } carry_t;

  // magnitudes
  logic [2:0]          sgn_a_r;
  logic [2:0][CW-1:0]  mag_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn_a_r[i] <= comp_in[i][CW-1];
        mag_a_r[i] <= comp_in[i][CW-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
      end
    end
  end

  // leading one of the largest magnitude
  logic [CW-1:0]       mx;
  logic [PW-1:0]       p_b_nxt;
  logic [2:0]          sgn_b_r;
  logic [2:0][CW-1:0]  mag_b_r;
  logic [PW-1:0]       p_b_r;
  logic                zero_b_r;

  always_comb begin
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      if (mag_a_r[i] > mx) mx = mag_a_r[i];
    end
    p_b_nxt = '0;
    for (int b = 0; b < CW; b++) begin
      if (mx[b]) p_b_nxt = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_b_r  <= sgn_a_r;
      mag_b_r  <= mag_a_r;
      p_b_r    <= p_b_nxt;
      zero_b_r <= (mx == '0);
    end
  end

  // bring the largest into [2^20, 2^21)
  logic [2:0][20:0] am_c_nxt;
  logic [SW-1:0]    ext [3];
  logic [SW-1:0]    sh  [3];
  carry_t           carry_c_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = SW'(mag_b_r[i]);
      if (p_b_r > PW'(20)) sh[i] = ext[i] >> (p_b_r - PW'(20));
      else sh[i] = ext[i] << (PW'(20) - p_b_r);
      am_c_nxt[i] = sh[i][20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_c_r.sgn  <= sgn_b_r;
      carry_c_r.zero <= zero_b_r;
      carry_c_r.am   <= am_c_nxt;
    end
  end

  // squares, then their sum scaled for the root
  logic [41:0] sq_d_r [3];
  carry_t      carry_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_d_r[i] <= 42'(carry_c_r.am[i]) * 42'(carry_c_r.am[i]);
      carry_d_r <= carry_c_r;
    end
  end

  logic [35:0] rm_r [0:31];
  logic [31:0] rt_r [0:32];
  logic [63:0] xs_r [0:31];
  carry_t      cs_r [0:32];

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r[0] <= {44'(sq_d_r[0]) + 44'(sq_d_r[1]) + 44'(sq_d_r[2]), 20'b0};
      rm_r[0] <= '0;
      rt_r[0] <= '0;
      cs_r[0] <= carry_d_r;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= 32; k++) begin : g_sqrt
    logic [35:0] rin;
    logic [35:0] trial;

    always_comb begin
      rin   = {rm_r[k-1][33:0], xs_r[k-1][63:62]};
      trial = {2'b00, rt_r[k-1], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[k] <= {rt_r[k-1][30:0], (rin >= trial)};
        cs_r[k] <= cs_r[k-1];
      end
    end

    if (k < 32) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rm_r[k] <= (rin >= trial) ? (rin - trial) : rin;
          xs_r[k] <= {xs_r[k-1][61:0], 2'b00};
        end
      end
    end
  end

  // divide each magnitude by the root, one quotient bit per stage
  logic [32:0]         rem_r [0:15][3];
  logic [15:0]         q_r   [0:16][3];
  logic [2:0]          ovf_r [0:16];
  logic [31:0]         r_r   [0:15];
  carry_t              dc_r  [0:16];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= rt_r[32];
      dc_r[0] <= cs_r[32];
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= {3'b000, cs_r[32].am[i], 9'b0};
        ovf_r[0][i] <= {2'b00, cs_r[32].am[i], 9'b0} >= rt_r[32];
        q_r[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 1; j <= 16; j++) begin : g_div
    logic [32:0] rs [3];
    logic [2:0]  ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rs[i] = {rem_r[j-1][i][31:0], 1'b0};
        ge[i] = rs[i] >= {1'b0, r_r[j-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) q_r[j][i] <= {q_r[j-1][i][14:0], ge[i]};
        ovf_r[j] <= ovf_r[j-1];
        dc_r[j]  <= dc_r[j-1];
      end
    end

    if (j < 16) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[j] <= r_r[j-1];
          for (int i = 0; i < 3; i++) begin
            rem_r[j][i] <= ge[i] ? (rs[i] - {1'b0, r_r[j-1]}) : rs[i];
          end
        end
      end
    end
  end

  // clamp and restore signs
  logic [UNIT_BITS-1:0] qc [3];
  unit_vec_t            vec_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ovf_r[16][i] || (UNIT_BITS'(q_r[16][i]) > UNIT_BITS'(UNIT_ONE))) begin
        qc[i] = UNIT_BITS'(UNIT_ONE);
      end else begin
        qc[i] = UNIT_BITS'(q_r[16][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r.nz <= !dc_r[16].zero;
      for (int i = 0; i < 3; i++) begin
        if (dc_r[16].zero) vec_r.u[i] <= '0;
        else if (dc_r[16].sgn[i]) vec_r.u[i] <= ~qc[i] + 1'b1;
        else vec_r.u[i] <= qc[i];
      end
    end
  end

  assign vec_out = vec_r;

endmodule
`default_nettype wire

// ===== rtl/core/two_light_phong_fragment_shader_unit.sv =====
// Two-light Blinn-Phong fragment shader.
// Input channel in_valid / in_stall / in_data carries one fragment: an
// unnormalized signed normal and an 8-bit texture color. Output channel
// out_valid / out_stall / out_data carries the shaded 8-bit RGB color.
// A transfer happens on a rising edge with valid high and stall low.
// One fragment is taken every cycle while no waiting result is stalled. The
// pipeline depth is set by the two normalizers in series (55 stages each:
// a 32-stage square root followed by a 16-stage divider), plus the dot
// product, five squarings and the per-light sum stages.
// Every stage advances together; when the receiver stalls with a result
// waiting, all stages hold and in_stall rises in the same cycle, so nothing
// is lost or repeated. Reset (rst_n low, synchronous) clears every valid bit;
// data registers keep whatever they held. A zero normal gives ambient only.
`default_nettype none
module two_light_phong_fragment_shader_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tlpfs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tlpfs_pkg::out_item_t    out_data
);
  import tlpfs_pkg::*;

  localparam int PIPE_LEN = 2 * NRM_LAT + 12;

  typedef struct packed {
    logic                      nz;
    logic [2:0][UNIT_BITS-1:0] n;
    logic [2:0][7:0]           col;
    logic [15:0]               d1;
    logic [15:0]               d2;
  } lag_t;

  function automatic logic [15:0] clamp_dot(input logic signed [35:0] sum);
    logic [20:0] v;
    v = sum[35:15];
    if (sum <= 0) return '0;
    if (v > 21'(UNIT_ONE)) return 16'(UNIT_ONE);
    return v[15:0];
  endfunction

  function automatic logic [15:0] sq_q15(input logic [15:0] s);
    logic [31:0] p;
    p = 32'(s) * 32'(s);
    return p[30:15];
  endfunction

  logic                en;
  logic [PIPE_LEN-1:0] vld_r;

  assign en       = !(vld_r[PIPE_LEN-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_valid};
    end
  end

  // input register and normal normalizer
  in_item_t              item_r;
  logic [2:0][NORMAL_BITS-1:0] n0_in;
  unit_vec_t             n0_vec;
  logic [2:0][7:0]       col_d_r [NRM_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      item_r     <= in_data;
      col_d_r[0] <= {item_r.diffuse_blue, item_r.diffuse_green, item_r.diffuse_red};
      for (int i = 1; i < NRM_LAT; i++) col_d_r[i] <= col_d_r[i-1];
    end
  end

  always_comb begin
    n0_in[0] = item_r.normal_x;
    n0_in[1] = item_r.normal_y;
    n0_in[2] = item_r.normal_z;
  end

  tlpfs_normalize #(.CW(NORMAL_BITS)) u_nrm_n (
    .clk(clk), .en(en), .comp_in(n0_in), .vec_out(n0_vec)
  );

  // light dot products and half vectors
  logic [2:0][UNIT_BITS-1:0] n_p1_r;
  logic                      nz_p1_r;
  logic [2:0][7:0]           col_p1_r;
  logic [2:0][HV_BITS-1:0]   hv1_r;
  logic [2:0][HV_BITS-1:0]   hv2_r;
  logic signed [33:0]        dp1_r [3];
  logic signed [33:0]        dp2_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      n_p1_r   <= n0_vec.u;
      nz_p1_r  <= n0_vec.nz;
      col_p1_r <= col_d_r[NRM_LAT-1];
      for (int i = 0; i < 3; i++) begin
        hv1_r[i] <= {n0_vec.u[i], 1'b0} - HV_BITS'(L1_COMP);
        dp1_r[i] <= 34'($signed(n0_vec.u[i])) * $signed(34'(L1_COMP));
      end
      hv2_r[0] <= {n0_vec.u[0], 1'b0} + HV_BITS'(L2_COMP);
      hv2_r[1] <= {n0_vec.u[1], 1'b0} - HV_BITS'(L2_COMP);
      hv2_r[2] <= {n0_vec.u[2], 1'b0};
      dp2_r[0] <= -(34'($signed(n0_vec.u[0])) * $signed(34'(L2_COMP)));
      dp2_r[1] <= 34'($signed(n0_vec.u[1])) * $signed(34'(L2_COMP));
    end
  end

  unit_vec_t h1_vec;
  unit_vec_t h2_vec;

  tlpfs_normalize #(.CW(HV_BITS)) u_nrm_h1 (
    .clk(clk), .en(en), .comp_in(hv1_r), .vec_out(h1_vec)
  );

  tlpfs_normalize #(.CW(HV_BITS)) u_nrm_h2 (
    .clk(clk), .en(en), .comp_in(hv2_r), .vec_out(h2_vec)
  );

  // hold the fragment alongside the half-vector normalizers
  lag_t lag_r [NRM_LAT];
  lag_t lg;

  always_ff @(posedge clk) begin
    if (en) begin
      lag_r[0].nz  <= nz_p1_r;
      lag_r[0].n   <= n_p1_r;
      lag_r[0].col <= col_p1_r;
      lag_r[0].d1  <= clamp_dot(36'(dp1_r[0]) + 36'(dp1_r[1]) + 36'(dp1_r[2]));
      lag_r[0].d2  <= clamp_dot(36'(dp2_r[0]) + 36'(dp2_r[1]));
      for (int i = 1; i < NRM_LAT; i++) lag_r[i] <= lag_r[i-1];
    end
  end

  assign lg = lag_r[NRM_LAT-1];

  // shading stages
  logic signed [33:0] nh_r  [2][3];
  logic [23:0]        cp_r  [2][3];
  logic [1:0]         hnz_r;
  logic [15:0]        d_q1_r [2];
  logic [15:0]        s_r   [2:7][2];
  logic [39:0]        m_r   [2][3];
  logic [40:0]        t_r   [2][3];
  logic [23:0]        y3_r  [2][3];
  logic [23:0]        y4_r  [2][3];
  logic [16:0]        q0_r  [2][3];
  logic [15:0]        df_r  [5:8][2][3];
  logic [15:0]        sp_r  [2];
  logic               nz_q_r [1:8];
  logic [16:0]        acc_r [3];
  logic [17:0]        acc_sum [3];
  logic [25:0]        resid [2][3];
  logic [24:0]        shade [3];
  out_item_t          out_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int c = 0; c < 3; c++) begin
        resid[l][c] = 26'(y4_r[l][c]) - 26'(q0_r[l][c]) * 26'(COLOR_MAX);
      end
    end
    for (int c = 0; c < 3; c++) begin
      acc_sum[c] = 18'(AMBIENT) + 18'(df_r[8][0][c]) + 18'(df_r[8][1][c])
                 + 18'(sp_r[0]) + 18'(sp_r[1]);
      shade[c] = 25'(acc_r[c]) * 25'(COLOR_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products with the half vectors, color times light power
      for (int i = 0; i < 3; i++) begin
        nh_r[0][i] <= 34'($signed(lg.n[i])) * 34'($signed(h1_vec.u[i]));
        nh_r[1][i] <= 34'($signed(lg.n[i])) * 34'($signed(h2_vec.u[i]));
        cp_r[0][i] <= 24'(lg.col[i]) * 24'(POW1);
        cp_r[1][i] <= 24'(lg.col[i]) * 24'(POW2);
      end
      hnz_r     <= {h2_vec.nz, h1_vec.nz};
      d_q1_r[0] <= lg.d1;
      d_q1_r[1] <= lg.d2;
      nz_q_r[1] <= lg.nz;
      for (int k = 2; k <= 8; k++) nz_q_r[k] <= nz_q_r[k-1];

      for (int l = 0; l < 2; l++) begin
        s_r[2][l] <= hnz_r[l] ?
                     clamp_dot(36'(nh_r[l][0]) + 36'(nh_r[l][1]) + 36'(nh_r[l][2])) : '0;
        for (int k = 3; k <= 7; k++) s_r[k][l] <= sq_q15(s_r[k-1][l]);
        sp_r[l] <= 16'(((32'(l == 0 ? KSP1 : KSP2)) * 32'(s_r[7][l])) >> 15);
        for (int c = 0; c < 3; c++) begin
          m_r[l][c]     <= 40'(cp_r[l][c]) * 40'(d_q1_r[l]);
          y3_r[l][c]    <= m_r[l][c][38:15];
          t_r[l][c]     <= 41'(m_r[l][c][38:15]) * 41'(RECIP_255);
          y4_r[l][c]    <= y3_r[l][c];
          q0_r[l][c]    <= t_r[l][c][40:24];
          // reciprocal estimate is at most one low
          df_r[5][l][c] <= 16'(q0_r[l][c] + 17'(resid[l][c] >= 26'(COLOR_MAX)));
          for (int k = 6; k <= 8; k++) df_r[k][l][c] <= df_r[k-1][l][c];
        end
      end

      for (int c = 0; c < 3; c++) begin
        if (!nz_q_r[8]) acc_r[c] <= 17'(AMBIENT);
        else if (acc_sum[c] > 18'(CLAMP_ONE)) acc_r[c] <= 17'(CLAMP_ONE);
        else acc_r[c] <= acc_sum[c][16:0];
      end

      out_r.shade_red   <= shade[0][23:16];
      out_r.shade_green <= shade[1][23:16];
      out_r.shade_blue  <= shade[2][23:16];
    end
  end

  assign out_valid = vld_r[PIPE_LEN-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/tlpfs_checker.sv =====
`default_nettype none
module tlpfs_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire tlpfs_pkg::out_item_t out_data
);
  import tlpfs_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the input holds exactly when a waiting result is stalled
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // ambient light alone already gives twelve
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.shade_red >= 8'd12) && (out_data.shade_green >= 8'd12)
                  && (out_data.shade_blue >= 8'd12))
    else $error("shade below ambient level");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind two_light_phong_fragment_shader_unit tlpfs_checker u_tlpfs_checker (.*);
`default_nettype wire
